// ----- rtl/core/dtq_pkg.sv -----
// ============================================================================
// dtq_pkg
// Shared types and constants for the deadline timer queue core.
// ============================================================================
package dtq_pkg;

    localparam int OS_DEPTH  = 16;
    localparam int PD_DEPTH  = 16;
    localparam int MAX_DEPTH = (OS_DEPTH > PD_DEPTH) ? OS_DEPTH : PD_DEPTH;
    localparam int OS_AW     = $clog2(OS_DEPTH);
    localparam int PD_AW     = $clog2(PD_DEPTH);
    localparam int OS_CW     = $clog2(OS_DEPTH + 1);
    localparam int PD_CW     = $clog2(PD_DEPTH + 1);
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);

    localparam logic [1:0] MODE_TICK     = 2'd0;
    localparam logic [1:0] MODE_ONESHOT  = 2'd1;
    localparam logic [1:0] MODE_PERIODIC = 2'd2;
    localparam logic [1:0] MODE_REMOVE   = 2'd3;

    localparam logic [1:0] KIND_ONESHOT  = 2'd0;
    localparam logic [1:0] KIND_PERIODIC = 2'd1;
    localparam logic [1:0] KIND_REPLY    = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [31:0] deadline;
        logic        sep;
        logic [15:0] tag;
    } os_entry_t;

    typedef struct packed {
        logic [31:0] deadline;
        logic [31:0] period;
        logic        sep;
        logic [15:0] tag;
        logic [15:0] id;
    } pd_entry_t;

endpackage

// ----- rtl/core/deadline_timer_queue_core.sv -----
// ============================================================================
// deadline_timer_queue_core
// Timer queue holding sorted one-shot timers and periodic timers in two
// single-port-read, single-port-write memories.
// ============================================================================
// A request is taken only while the sequencer is idle, and s_ready stays low
// until its work is done. Each stored entry that a request visits is first
// read from the memory, and the registered read data is then acted on. An add
// one-shot walks and shifts the stored one-shots, an add periodic shifts the
// stored periodic timers, a remove searches and shifts them, and a tick walks
// both stores; each also stays busy while it waits on m_ready. A request that
// finds its store full goes straight to its reply. The single read port of
// each memory makes a request visit its entries one at a time. Results of a
// tick pass through a pending stage and the output register, and the last
// one carries m_last.
module deadline_timer_queue_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [31:0] s_time_now,
    input  logic [31:0] s_delay,
    input  logic [15:0] s_handler_tag,
    input  logic        s_separate,
    input  logic [15:0] s_remove_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_fired_tag,
    output logic        m_fired_separate,
    output logic [15:0] m_timer_id,
    output logic [1:0]  m_status,
    output logic        m_last
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_T_ORD = 5'd1;
    localparam logic [4:0] ST_T_OEV = 5'd2;
    localparam logic [4:0] ST_T_CRD = 5'd3;
    localparam logic [4:0] ST_T_CWR = 5'd4;
    localparam logic [4:0] ST_T_PRD = 5'd5;
    localparam logic [4:0] ST_T_PEV = 5'd6;
    localparam logic [4:0] ST_FLUSH = 5'd7;
    localparam logic [4:0] ST_A_RD  = 5'd8;
    localparam logic [4:0] ST_A_EV  = 5'd9;
    localparam logic [4:0] ST_A_SH  = 5'd10;
    localparam logic [4:0] ST_A_SW  = 5'd11;
    localparam logic [4:0] ST_P_SH  = 5'd12;
    localparam logic [4:0] ST_P_SW  = 5'd13;
    localparam logic [4:0] ST_R_RD  = 5'd14;
    localparam logic [4:0] ST_R_EV  = 5'd15;
    localparam logic [4:0] ST_R_SH  = 5'd16;
    localparam logic [4:0] ST_R_SW  = 5'd17;
    localparam logic [4:0] ST_REPLY = 5'd18;

    dtq_pkg::os_entry_t os_mem [dtq_pkg::OS_DEPTH];
    dtq_pkg::pd_entry_t pd_mem [dtq_pkg::PD_DEPTH];

    dtq_pkg::os_entry_t os_rdata_reg, os_wdata;
    dtq_pkg::pd_entry_t pd_rdata_reg, pd_wdata;
    logic os_re, os_we, pd_re, pd_we;
    logic [dtq_pkg::OS_AW-1:0] os_raddr, os_waddr;
    logic [dtq_pkg::PD_AW-1:0] pd_raddr, pd_waddr;

    logic [4:0]  state_reg, state_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] delay_reg, delay_next;
    logic [31:0] add_dl_reg, add_dl_next;
    logic [15:0] tag_reg, tag_next;
    logic        sep_reg, sep_next;
    logic [15:0] rid_reg, rid_next;
    logic [dtq_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [dtq_pkg::CNT_W-1:0] ptr_reg, ptr_next;
    logic [dtq_pkg::OS_CW-1:0] ocnt_reg, ocnt_next;
    logic [dtq_pkg::PD_CW-1:0] pcnt_reg, pcnt_next;
    logic [15:0] next_id_reg, next_id_next;
    logic [15:0] spare_id_reg, spare_id_next;
    logic [15:0] reply_id_reg, reply_id_next;
    logic [1:0]  reply_status_reg, reply_status_next;

    logic        pend_valid_reg, pend_valid_next;
    logic [1:0]  pend_kind_reg, pend_kind_next;
    logic [15:0] pend_tag_reg, pend_tag_next;
    logic        pend_sep_reg, pend_sep_next;
    logic [15:0] pend_id_reg, pend_id_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_kind_reg, m_kind_next;
    logic [15:0] m_tag_reg, m_tag_next;
    logic        m_sep_reg, m_sep_next;
    logic [15:0] m_id_reg, m_id_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic        m_last_reg, m_last_next;

    logic        can_push, emit_ok, emit_req, flush_req, reply_req;
    logic [1:0]  emit_kind;
    logic [15:0] emit_tag, emit_id, new_id, inc_id;
    logic        emit_sep;

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_kind           = m_kind_reg;
    assign m_fired_tag      = m_tag_reg;
    assign m_fired_separate = m_sep_reg;
    assign m_timer_id       = m_id_reg;
    assign m_status         = m_status_reg;
    assign m_last           = m_last_reg;

    assign can_push = !m_valid_reg || m_ready;
    assign emit_ok  = !pend_valid_reg || can_push;
    assign inc_id   = (next_id_reg == 16'hFFFF) ? 16'd1 : next_id_reg + 16'd1;
    assign new_id   = (spare_id_reg != 16'd0) ? spare_id_reg : inc_id;

    always_ff @(posedge aclk) begin
        if (os_we) begin
            os_mem[os_waddr] <= os_wdata;
        end
        if (os_re) begin
            os_rdata_reg <= os_mem[os_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pd_we) begin
            pd_mem[pd_waddr] <= pd_wdata;
        end
        if (pd_re) begin
            pd_rdata_reg <= pd_mem[pd_raddr];
        end
    end

    always_comb begin
        state_next        = state_reg;
        now_next          = now_reg;
        delay_next        = delay_reg;
        add_dl_next       = add_dl_reg;
        tag_next          = tag_reg;
        sep_next          = sep_reg;
        rid_next          = rid_reg;
        idx_next          = idx_reg;
        ptr_next          = ptr_reg;
        ocnt_next         = ocnt_reg;
        pcnt_next         = pcnt_reg;
        next_id_next      = next_id_reg;
        spare_id_next     = spare_id_reg;
        reply_id_next     = reply_id_reg;
        reply_status_next = reply_status_reg;
        pend_valid_next   = pend_valid_reg;
        pend_kind_next    = pend_kind_reg;
        pend_tag_next     = pend_tag_reg;
        pend_sep_next     = pend_sep_reg;
        pend_id_next      = pend_id_reg;
        m_valid_next      = m_valid_reg;
        m_kind_next       = m_kind_reg;
        m_tag_next        = m_tag_reg;
        m_sep_next        = m_sep_reg;
        m_id_next         = m_id_reg;
        m_status_next     = m_status_reg;
        m_last_next       = m_last_reg;
        os_re    = 1'b0;
        os_we    = 1'b0;
        os_raddr = '0;
        os_waddr = '0;
        os_wdata = os_rdata_reg;
        pd_re    = 1'b0;
        pd_we    = 1'b0;
        pd_raddr = '0;
        pd_waddr = '0;
        pd_wdata = pd_rdata_reg;
        emit_req  = 1'b0;
        emit_kind = dtq_pkg::KIND_ONESHOT;
        emit_tag  = os_rdata_reg.tag;
        emit_sep  = os_rdata_reg.sep;
        emit_id   = 16'd0;
        flush_req = 1'b0;
        reply_req = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    now_next          = s_time_now;
                    delay_next        = s_delay;
                    add_dl_next       = s_time_now + s_delay;
                    tag_next          = s_handler_tag;
                    sep_next          = s_separate;
                    rid_next          = s_remove_id;
                    idx_next          = '0;
                    reply_id_next     = 16'd0;
                    reply_status_next = dtq_pkg::STAT_OK;
                    unique case (s_mode)
                        dtq_pkg::MODE_TICK: begin
                            state_next = ST_T_ORD;
                        end
                        dtq_pkg::MODE_ONESHOT: begin
                            if (ocnt_reg == dtq_pkg::OS_CW'(dtq_pkg::OS_DEPTH)) begin
                                reply_status_next = dtq_pkg::STAT_FULL;
                                state_next        = ST_REPLY;
                            end else begin
                                state_next = ST_A_RD;
                            end
                        end
                        dtq_pkg::MODE_PERIODIC: begin
                            if (pcnt_reg == dtq_pkg::PD_CW'(dtq_pkg::PD_DEPTH)) begin
                                reply_status_next = dtq_pkg::STAT_FULL;
                                state_next        = ST_REPLY;
                            end else begin
                                if (spare_id_reg == 16'd0) begin
                                    next_id_next = inc_id;
                                end
                                spare_id_next = 16'd0;
                                reply_id_next = new_id;
                                ptr_next      = dtq_pkg::CNT_W'(pcnt_reg);
                                state_next    = ST_P_SH;
                            end
                        end
                        default: begin
                            reply_id_next = s_remove_id;
                            state_next    = ST_R_RD;
                        end
                    endcase
                end
            end
            ST_T_ORD: begin
                if (idx_reg == dtq_pkg::CNT_W'(ocnt_reg)) begin
                    ptr_next   = idx_reg;
                    state_next = ST_T_CRD;
                end else begin
                    os_re      = 1'b1;
                    os_raddr   = idx_reg[dtq_pkg::OS_AW-1:0];
                    state_next = ST_T_OEV;
                end
            end
            ST_T_OEV: begin
                if (now_reg >= os_rdata_reg.deadline) begin
                    emit_req = 1'b1;
                    if (emit_ok) begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_T_ORD;
                    end
                end else begin
                    ptr_next   = idx_reg;
                    state_next = ST_T_CRD;
                end
            end
            ST_T_CRD: begin
                if (ptr_reg == dtq_pkg::CNT_W'(ocnt_reg) || idx_reg == '0) begin
                    ocnt_next  = ocnt_reg - dtq_pkg::OS_CW'(idx_reg);
                    idx_next   = '0;
                    state_next = ST_T_PRD;
                end else begin
                    os_re      = 1'b1;
                    os_raddr   = ptr_reg[dtq_pkg::OS_AW-1:0];
                    state_next = ST_T_CWR;
                end
            end
            ST_T_CWR: begin
                os_we      = 1'b1;
                os_waddr   = dtq_pkg::OS_AW'(ptr_reg - idx_reg);
                ptr_next   = ptr_reg + 1'b1;
                state_next = ST_T_CRD;
            end
            ST_T_PRD: begin
                if (idx_reg == dtq_pkg::CNT_W'(pcnt_reg)) begin
                    state_next = ST_FLUSH;
                end else begin
                    pd_re      = 1'b1;
                    pd_raddr   = idx_reg[dtq_pkg::PD_AW-1:0];
                    state_next = ST_T_PEV;
                end
            end
            ST_T_PEV: begin
                emit_kind = dtq_pkg::KIND_PERIODIC;
                emit_tag  = pd_rdata_reg.tag;
                emit_sep  = pd_rdata_reg.sep;
                emit_id   = pd_rdata_reg.id;
                if (now_reg >= pd_rdata_reg.deadline) begin
                    emit_req = 1'b1;
                    if (emit_ok) begin
                        pd_we             = 1'b1;
                        pd_waddr          = idx_reg[dtq_pkg::PD_AW-1:0];
                        pd_wdata.deadline = now_reg + pd_rdata_reg.period;
                        idx_next          = idx_reg + 1'b1;
                        state_next        = ST_T_PRD;
                    end
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_T_PRD;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (can_push) begin
                    flush_req  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_A_RD: begin
                if (idx_reg == dtq_pkg::CNT_W'(ocnt_reg)) begin
                    ptr_next   = dtq_pkg::CNT_W'(ocnt_reg);
                    state_next = ST_A_SH;
                end else begin
                    os_re      = 1'b1;
                    os_raddr   = idx_reg[dtq_pkg::OS_AW-1:0];
                    state_next = ST_A_EV;
                end
            end
            ST_A_EV: begin
                if (os_rdata_reg.deadline <= add_dl_reg) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_A_RD;
                end else begin
                    ptr_next   = dtq_pkg::CNT_W'(ocnt_reg);
                    state_next = ST_A_SH;
                end
            end
            ST_A_SH: begin
                if (ptr_reg == idx_reg) begin
                    os_we             = 1'b1;
                    os_waddr          = idx_reg[dtq_pkg::OS_AW-1:0];
                    os_wdata.deadline = add_dl_reg;
                    os_wdata.sep      = sep_reg;
                    os_wdata.tag      = tag_reg;
                    ocnt_next         = ocnt_reg + 1'b1;
                    state_next        = ST_REPLY;
                end else begin
                    os_re      = 1'b1;
                    os_raddr   = dtq_pkg::OS_AW'(ptr_reg - 1'b1);
                    state_next = ST_A_SW;
                end
            end
            ST_A_SW: begin
                os_we      = 1'b1;
                os_waddr   = ptr_reg[dtq_pkg::OS_AW-1:0];
                ptr_next   = ptr_reg - 1'b1;
                state_next = ST_A_SH;
            end
            ST_P_SH: begin
                if (ptr_reg == '0) begin
                    pd_we             = 1'b1;
                    pd_waddr          = '0;
                    pd_wdata.deadline = add_dl_reg;
                    pd_wdata.period   = delay_reg;
                    pd_wdata.sep      = sep_reg;
                    pd_wdata.tag      = tag_reg;
                    pd_wdata.id       = reply_id_reg;
                    pcnt_next         = pcnt_reg + 1'b1;
                    state_next        = ST_REPLY;
                end else begin
                    pd_re      = 1'b1;
                    pd_raddr   = dtq_pkg::PD_AW'(ptr_reg - 1'b1);
                    state_next = ST_P_SW;
                end
            end
            ST_P_SW: begin
                pd_we      = 1'b1;
                pd_waddr   = ptr_reg[dtq_pkg::PD_AW-1:0];
                ptr_next   = ptr_reg - 1'b1;
                state_next = ST_P_SH;
            end
            ST_R_RD: begin
                if (idx_reg == dtq_pkg::CNT_W'(pcnt_reg)) begin
                    reply_status_next = dtq_pkg::STAT_NOTFOUND;
                    state_next        = ST_REPLY;
                end else begin
                    pd_re      = 1'b1;
                    pd_raddr   = idx_reg[dtq_pkg::PD_AW-1:0];
                    state_next = ST_R_EV;
                end
            end
            ST_R_EV: begin
                if (pd_rdata_reg.id == rid_reg) begin
                    ptr_next   = idx_reg;
                    state_next = ST_R_SH;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_R_RD;
                end
            end
            ST_R_SH: begin
                if (ptr_reg + 1'b1 == dtq_pkg::CNT_W'(pcnt_reg)) begin
                    pcnt_next = pcnt_reg - 1'b1;
                    if (spare_id_reg == 16'd0) begin
                        spare_id_next = rid_reg;
                    end
                    state_next = ST_REPLY;
                end else begin
                    pd_re      = 1'b1;
                    pd_raddr   = dtq_pkg::PD_AW'(ptr_reg + 1'b1);
                    state_next = ST_R_SW;
                end
            end
            ST_R_SW: begin
                pd_we      = 1'b1;
                pd_waddr   = ptr_reg[dtq_pkg::PD_AW-1:0];
                ptr_next   = ptr_reg + 1'b1;
                state_next = ST_R_SH;
            end
            ST_REPLY: begin
                reply_req = 1'b1;
                if (can_push) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (reply_req && can_push) begin
            m_valid_next  = 1'b1;
            m_kind_next   = dtq_pkg::KIND_REPLY;
            m_tag_next    = 16'd0;
            m_sep_next    = 1'b0;
            m_id_next     = reply_id_reg;
            m_status_next = reply_status_reg;
            m_last_next   = 1'b1;
        end
        if (flush_req || (emit_req && emit_ok && pend_valid_reg)) begin
            m_valid_next    = 1'b1;
            m_kind_next     = pend_kind_reg;
            m_tag_next      = pend_tag_reg;
            m_sep_next      = pend_sep_reg;
            m_id_next       = pend_id_reg;
            m_status_next   = dtq_pkg::STAT_OK;
            m_last_next     = flush_req;
            pend_valid_next = 1'b0;
        end
        if (emit_req && emit_ok) begin
            pend_valid_next = 1'b1;
            pend_kind_next  = emit_kind;
            pend_tag_next   = emit_tag;
            pend_sep_next   = emit_sep;
            pend_id_next    = emit_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ocnt_reg       <= '0;
            pcnt_reg       <= '0;
            next_id_reg    <= 16'd0;
            spare_id_reg   <= 16'd0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ocnt_reg       <= ocnt_next;
            pcnt_reg       <= pcnt_next;
            next_id_reg    <= next_id_next;
            spare_id_reg   <= spare_id_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg          <= now_next;
        delay_reg        <= delay_next;
        add_dl_reg       <= add_dl_next;
        tag_reg          <= tag_next;
        sep_reg          <= sep_next;
        rid_reg          <= rid_next;
        idx_reg          <= idx_next;
        ptr_reg          <= ptr_next;
        reply_id_reg     <= reply_id_next;
        reply_status_reg <= reply_status_next;
        pend_kind_reg    <= pend_kind_next;
        pend_tag_reg     <= pend_tag_next;
        pend_sep_reg     <= pend_sep_next;
        pend_id_reg      <= pend_id_next;
        m_kind_reg       <= m_kind_next;
        m_tag_reg        <= m_tag_next;
        m_sep_reg        <= m_sep_next;
        m_id_reg         <= m_id_next;
        m_status_reg     <= m_status_next;
        m_last_reg       <= m_last_next;
    end

    a_ocnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ocnt_reg <= dtq_pkg::OS_CW'(dtq_pkg::OS_DEPTH))
        else $error("One-shot count exceeds the store depth.");

    a_pcnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pcnt_reg <= dtq_pkg::PD_CW'(dtq_pkg::PD_DEPTH))
        else $error("Periodic count exceeds the store depth.");

    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("A fired result is still pending while idle.");

    a_os_no_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        (os_we && os_re) |-> (os_waddr != os_raddr))
        else $error("One-shot memory read and write hit the same entry.");

endmodule

// ----- dv/tb_deadline_timer_queue_core.sv -----
// ============================================================================
// tb_deadline_timer_queue_core
// Self-checking testbench for the deadline timer queue core. A directed table
// of requests and a store fill and overflow phase are followed by random traffic. Every accepted request is run
// through a local timer queue model, and each result that leaves the core is
// compared field by field with the oldest predicted result.
// ============================================================================
`timescale 1ns / 100ps

module tb_deadline_timer_queue_core;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] tag;
        logic        sep;
        logic [15:0] id;
        logic [1:0]  status;
        logic        last;
    } timer_result_t;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] now;
        logic [31:0] delay;
        logic [15:0] tag;
        logic        sep;
        logic [15:0] rid;
        bit          typed;
        logic [1:0]  exp_status;
        logic [15:0] exp_id;
    } request_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = dtq_pkg::MODE_TICK;
    logic [31:0] s_time_now = '0;
    logic [31:0] s_delay = '0;
    logic [15:0] s_handler_tag = '0;
    logic        s_separate = 1'b0;
    logic [15:0] s_remove_id = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [15:0] m_fired_tag;
    logic        m_fired_separate;
    logic [15:0] m_timer_id;
    logic [1:0]  m_status;
    logic        m_last;

    deadline_timer_queue_core dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Local copy of the timer stores.
    logic [31:0] os_deadline [dtq_pkg::OS_DEPTH];
    logic [15:0] os_tag [dtq_pkg::OS_DEPTH];
    logic        os_sep [dtq_pkg::OS_DEPTH];
    int          os_count;
    logic [31:0] pd_deadline [dtq_pkg::PD_DEPTH];
    logic [31:0] pd_period [dtq_pkg::PD_DEPTH];
    logic [15:0] pd_tag [dtq_pkg::PD_DEPTH];
    logic        pd_sep [dtq_pkg::PD_DEPTH];
    logic [15:0] pd_id [dtq_pkg::PD_DEPTH];
    int          pd_count;
    logic [15:0] id_counter;
    logic [15:0] freed_id;

    timer_result_t expected_results [$];
    timer_result_t request_results [$];
    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;
    bit long_hold_req = 0;
    bit long_hold_done = 0;
    int hold_left = 0;
    int accepted = 0;
    int checked = 0;

    function automatic timer_result_t mk(logic [1:0] kind, logic [15:0] tag, logic sep,
                                         logic [15:0] id, logic [1:0] status);
        timer_result_t r;
        r.kind = kind; r.tag = tag; r.sep = sep; r.id = id; r.status = status;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic queue_model(input logic [1:0] mode, input logic [31:0] now,
                               input logic [31:0] delay, input logic [15:0] tag,
                               input logic sep, input logic [15:0] rid);
        int fired;
        int pos;
        int hit;
        logic [31:0] dl;
        logic [15:0] id;
        request_results.delete();
        case (mode)
            dtq_pkg::MODE_TICK: begin
                fired = 0;
                while (fired < os_count && request_results.size() < 32 &&
                       now >= os_deadline[fired]) begin
                    request_results.push_back(mk(dtq_pkg::KIND_ONESHOT, os_tag[fired],
                                                 os_sep[fired], 16'd0, dtq_pkg::STAT_OK));
                    fired++;
                end
                for (int i = fired; i < os_count; i++) begin
                    os_deadline[i-fired] = os_deadline[i];
                    os_tag[i-fired] = os_tag[i];
                    os_sep[i-fired] = os_sep[i];
                end
                os_count -= fired;
                for (int i = 0; i < pd_count && request_results.size() < 32; i++) begin
                    if (now >= pd_deadline[i]) begin
                        request_results.push_back(mk(dtq_pkg::KIND_PERIODIC, pd_tag[i],
                                                     pd_sep[i], pd_id[i],
                                                     dtq_pkg::STAT_OK));
                        pd_deadline[i] = now + pd_period[i];
                    end
                end
            end
            dtq_pkg::MODE_ONESHOT: begin
                if (os_count >= dtq_pkg::OS_DEPTH) begin
                    request_results.push_back(mk(dtq_pkg::KIND_REPLY, 0, 0, 0,
                                                 dtq_pkg::STAT_FULL));
                end else begin
                    dl = now + delay;
                    pos = 0;
                    while (pos < os_count && os_deadline[pos] <= dl) pos++;
                    for (int i = os_count; i > pos; i--) begin
                        os_deadline[i] = os_deadline[i-1];
                        os_tag[i] = os_tag[i-1];
                        os_sep[i] = os_sep[i-1];
                    end
                    os_deadline[pos] = dl;
                    os_tag[pos] = tag;
                    os_sep[pos] = sep;
                    os_count++;
                    request_results.push_back(mk(dtq_pkg::KIND_REPLY, 0, 0, 0,
                                                 dtq_pkg::STAT_OK));
                end
            end
            dtq_pkg::MODE_PERIODIC: begin
                if (pd_count >= dtq_pkg::PD_DEPTH) begin
                    request_results.push_back(mk(dtq_pkg::KIND_REPLY, 0, 0, 0,
                                                 dtq_pkg::STAT_FULL));
                end else begin
                    if (freed_id != 0) begin
                        id = freed_id;
                    end else begin
                        id_counter = id_counter + 16'd1;
                        if (id_counter == 0) id_counter = 16'd1;
                        id = id_counter;
                    end
                    freed_id = 0;
                    for (int i = pd_count; i > 0; i--) begin
                        pd_deadline[i] = pd_deadline[i-1];
                        pd_period[i] = pd_period[i-1];
                        pd_tag[i] = pd_tag[i-1];
                        pd_sep[i] = pd_sep[i-1];
                        pd_id[i] = pd_id[i-1];
                    end
                    pd_deadline[0] = now + delay;
                    pd_period[0] = delay;
                    pd_tag[0] = tag;
                    pd_sep[0] = sep;
                    pd_id[0] = id;
                    pd_count++;
                    request_results.push_back(mk(dtq_pkg::KIND_REPLY, 0, 0, id,
                                                 dtq_pkg::STAT_OK));
                end
            end
            default: begin
                hit = -1;
                for (int i = 0; i < pd_count; i++) begin
                    if (hit < 0 && pd_id[i] == rid) hit = i;
                end
                if (hit >= 0) begin
                    for (int i = hit; i + 1 < pd_count; i++) begin
                        pd_deadline[i] = pd_deadline[i+1];
                        pd_period[i] = pd_period[i+1];
                        pd_tag[i] = pd_tag[i+1];
                        pd_sep[i] = pd_sep[i+1];
                        pd_id[i] = pd_id[i+1];
                    end
                    pd_count--;
                    if (freed_id == 0) freed_id = rid;
                    request_results.push_back(mk(dtq_pkg::KIND_REPLY, 0, 0, rid,
                                                 dtq_pkg::STAT_OK));
                end else begin
                    request_results.push_back(mk(dtq_pkg::KIND_REPLY, 0, 0, rid,
                                                 dtq_pkg::STAT_NOTFOUND));
                end
            end
        endcase
        if (request_results.size() > 0)
            request_results[request_results.size()-1].last = 1'b1;
    endtask

    task automatic send_request(input request_row_t row);
        timer_result_t r;
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= row.mode;
        s_time_now <= row.now;
        s_delay <= row.delay;
        s_handler_tag <= row.tag;
        s_separate <= row.sep;
        s_remove_id <= row.rid;
        do @(posedge aclk); while (!s_ready);
        accepted++;
        queue_model(row.mode, row.now, row.delay, row.tag, row.sep, row.rid);
        if (row.typed) begin
            r = mk(dtq_pkg::KIND_REPLY, 0, 0, row.exp_id, row.exp_status);
            r.last = 1'b1;
            expected_results.push_back(r);
        end else begin
            foreach (request_results[i]) expected_results.push_back(request_results[i]);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() > 0) @(posedge aclk);
    endtask

    function automatic request_row_t row_of(logic [1:0] mode, logic [31:0] now,
                                            logic [31:0] delay, logic [15:0] tag,
                                            logic sep, logic [15:0] rid);
        request_row_t row;
        row.mode = mode; row.now = now; row.delay = delay; row.tag = tag;
        row.sep = sep; row.rid = rid; row.typed = 0;
        row.exp_status = dtq_pkg::STAT_OK; row.exp_id = 0;
        return row;
    endfunction

    function automatic request_row_t typed_row(request_row_t row, logic [1:0] status,
                                               logic [15:0] id);
        row.typed = 1; row.exp_status = status; row.exp_id = id;
        return row;
    endfunction

    function automatic request_row_t random_request(inout logic [31:0] clock_ms);
        request_row_t row;
        int pick;
        logic [31:0] dly;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0) clock_ms = $urandom();
        else clock_ms = clock_ms + $urandom_range(0, 40);
        dly = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 120);
        row = row_of(dtq_pkg::MODE_TICK, clock_ms, $urandom(), $urandom_range(0, 65535),
                     $urandom_range(0, 1), $urandom_range(0, 65535));
        if (pick < 35) begin
            row.mode = dtq_pkg::MODE_TICK;
        end else if (pick < 65) begin
            row.mode = dtq_pkg::MODE_ONESHOT;
            row.delay = dly;
        end else if (pick < 82) begin
            row.mode = dtq_pkg::MODE_PERIODIC;
            row.delay = dly;
        end else begin
            row.mode = dtq_pkg::MODE_REMOVE;
            if (pd_count > 0 && $urandom_range(0, 3) != 0)
                row.rid = pd_id[$urandom_range(0, pd_count - 1)];
        end
        return row;
    endfunction

    always @(posedge aclk) begin
        if (long_hold_req && !long_hold_done) begin
            long_hold_done <= 1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        timer_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result kind=%0d id=%0d", m_kind, m_timer_id);
                errors++;
            end else begin
                e = expected_results.pop_front();
                checked++;
                if (m_kind !== e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, m_kind); errors++;
                end
                if (m_fired_tag !== e.tag) begin
                    $error("fired_tag: expected %h, got %h", e.tag, m_fired_tag); errors++;
                end
                if (m_fired_separate !== e.sep) begin
                    $error("fired_separate: expected %0d, got %0d", e.sep, m_fired_separate);
                    errors++;
                end
                if (m_timer_id !== e.id) begin
                    $error("timer_id: expected %0d, got %0d", e.id, m_timer_id); errors++;
                end
                if (m_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_status); errors++;
                end
                if (m_last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, m_last); errors++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("deadline_timer_queue_core test failed");
        $finish;
    end

    initial begin
        request_row_t table_rows [$];
        request_row_t row;
        logic [31:0] clock_ms;
        os_count = 0;
        pd_count = 0;
        id_counter = 0;
        freed_id = 0;

        table_rows.push_back(row_of(dtq_pkg::MODE_TICK, 32'd0, 32'd0, 16'd0, 1'b0, 16'd0));
        table_rows.push_back(typed_row(row_of(dtq_pkg::MODE_REMOVE, 0, 0, 0, 0, 16'd0),
                                       dtq_pkg::STAT_NOTFOUND, 16'd0));
        table_rows.push_back(typed_row(row_of(dtq_pkg::MODE_PERIODIC, 0, 32'd0,
                                              16'hFFFF, 1, 0),
                                       dtq_pkg::STAT_OK, 16'd1));
        table_rows.push_back(typed_row(row_of(dtq_pkg::MODE_PERIODIC, 0, 32'hFFFFFFFF,
                                              0, 0, 0),
                                       dtq_pkg::STAT_OK, 16'd2));
        table_rows.push_back(typed_row(row_of(dtq_pkg::MODE_REMOVE, 0, 0, 0, 0, 16'd1),
                                       dtq_pkg::STAT_OK, 16'd1));
        table_rows.push_back(typed_row(row_of(dtq_pkg::MODE_REMOVE, 0, 0, 0, 0, 16'hFFFF),
                                       dtq_pkg::STAT_NOTFOUND, 16'hFFFF));
        table_rows.push_back(typed_row(row_of(dtq_pkg::MODE_REMOVE, 0, 0, 0, 0, 16'd2),
                                       dtq_pkg::STAT_OK, 16'd2));
        table_rows.push_back(typed_row(row_of(dtq_pkg::MODE_PERIODIC, 32'd5, 32'd10,
                                              16'h1234, 0, 0),
                                       dtq_pkg::STAT_OK, 16'd1));
        table_rows.push_back(typed_row(row_of(dtq_pkg::MODE_PERIODIC, 32'd5, 32'd3,
                                              16'h00FF, 1, 0),
                                       dtq_pkg::STAT_OK, 16'd3));
        table_rows.push_back(row_of(dtq_pkg::MODE_ONESHOT, 32'd100, 32'd0, 16'hAAAA, 1, 0));
        table_rows.push_back(row_of(dtq_pkg::MODE_ONESHOT, 32'd0, 32'hFFFFFFFF,
                                    16'h5555, 0, 0));
        table_rows.push_back(row_of(dtq_pkg::MODE_ONESHOT, 32'd50, 32'd50, 16'h0001, 0, 0));
        table_rows.push_back(row_of(dtq_pkg::MODE_ONESHOT, 32'hFFFFFFFF, 32'd0,
                                    16'hFFFF, 1, 0));
        table_rows.push_back(row_of(dtq_pkg::MODE_ONESHOT, 32'hFFFFFFFF, 32'd1,
                                    16'h0000, 0, 0));
        table_rows.push_back(row_of(dtq_pkg::MODE_ONESHOT, 32'd10, 32'd20, 16'h8000, 1, 0));
        table_rows.push_back(row_of(dtq_pkg::MODE_TICK, 32'd30, 0, 0, 0, 0));
        table_rows.push_back(row_of(dtq_pkg::MODE_TICK, 32'd100, 0, 0, 0, 0));
        table_rows.push_back(row_of(dtq_pkg::MODE_TICK, 32'd99, 0, 0, 0, 0));
        table_rows.push_back(row_of(dtq_pkg::MODE_TICK, 32'hFFFFFFFF, 0, 0, 0, 0));
        table_rows.push_back(row_of(dtq_pkg::MODE_TICK, 32'hFFFFFFFF, 0, 0, 0, 0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (table_rows[i]) send_request(table_rows[i]);
        drain_results();

        // Fill both stores while the result side is held off, then overflow
        // each and fire everything with one tick at the top of the time range.
        long_hold_req = 1;
        clock_ms = 32'h1000;
        for (int i = 0; i < dtq_pkg::OS_DEPTH + 1 - os_count + 1; i++)
            send_request(row_of(dtq_pkg::MODE_ONESHOT, clock_ms,
                                $urandom_range(1000, 100000),
                                $urandom_range(0, 65535), $urandom_range(0, 1), 0));
        for (int i = 0; i < dtq_pkg::PD_DEPTH + 1 - pd_count + 1; i++)
            send_request(row_of(dtq_pkg::MODE_PERIODIC, clock_ms,
                                $urandom_range(1000, 100000),
                                $urandom_range(0, 65535), $urandom_range(0, 1), 0));
        send_request(row_of(dtq_pkg::MODE_TICK, 32'hFFFFFFFF, 0, 0, 0, 0));
        drain_results();
        while (pd_count > 0)
            send_request(row_of(dtq_pkg::MODE_REMOVE, 0, 0, 0, 0, pd_id[0]));
        send_request(row_of(dtq_pkg::MODE_TICK, 32'hFFFFFFFF, 0, 0, 0, 0));
        drain_results();

        clock_ms = 32'hFFFFF000;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 26 : (phase == 1) ? 83 : 0;
            recv_idle = (phase == 0) ? 83 : (phase == 1) ? 26 : 0;
            for (int i = 0; i < 45; i++) begin
                row = random_request(clock_ms);
                send_request(row);
            end
            drain_results();
        end

        repeat (200) @(posedge aclk);
        $display("Covered %0d requests and checked %0d results, including full stores,",
                 accepted, checked);
        $display("wrapped deadlines, spare id reuse, ticks firing both full stores and"
                 , " long output stalls.");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("deadline_timer_queue_core test passed");
        end else begin
            $display("deadline_timer_queue_core test failed");
        end
        $finish;
    end

endmodule
